// File: sv/rhct_pkg.sv
// Shared types and constants for the ranked hit-count table.
package rhct_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned POS_W       = 8;
  localparam int unsigned CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned ENTRY_W     = 56;

  // Request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_SIGHT = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Saturation limit of the hit count
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] url_key;
    logic [31:0] page_rank;
    logic [7:0]  position;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] entry_key;
    logic [7:0]  entry_count;
    logic [31:0] entry_rank;
    logic [7:0]  new_position;
  } rsp_t;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  count;
    logic [31:0] rank;
  } entry_t;

endpackage

// File: sv/rhct_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module rhct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, then register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/ranked_hit_count_table.sv
// Ranked hit-count table: sorted entry store with search and bubble-up on sightings.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------
//   in      | input     | in_valid_i / in_ready_o   | in_req_i  (rhct_pkg::req_t)
//   out     | output    | out_valid_o / out_ready_i | out_rsp_o (rhct_pkg::rsp_t)
//
// One request at a time; the entry RAM (one write, one registered read per
// cycle) sets the pace. A load passes through S_EMIT, a read through S_RDWAIT
// and S_EMIT; a sighting scans in S_SEARCH and on a hit swaps toward the front in
// S_BUBBLE (S_FINAL for the front slot), then S_EMIT waits for a free output register.
// Reset clears the fill count and control; the RAM is not cleared.
// A new request is taken while the previous result waits in the output register.
module ranked_hit_count_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rhct_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rhct_pkg::rsp_t out_rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_BUBBLE,
    S_FINAL,
    S_RDWAIT,
    S_EMIT
  } state_e;

  state_e                         state_q, state_d;
  logic [rhct_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [rhct_pkg::ADDR_W-1:0]    idx_q, idx_d;
  logic [15:0]                    key_q, key_d;
  rhct_pkg::entry_t               mv_q, mv_d;
  rhct_pkg::rsp_t                 res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  rhct_pkg::rsp_t                 out_rsp_q, out_rsp_d;

  logic                           ram_we;
  logic [rhct_pkg::ADDR_W-1:0]    ram_waddr;
  rhct_pkg::entry_t               ram_wdata;
  logic [rhct_pkg::ADDR_W-1:0]    ram_raddr;
  logic [rhct_pkg::ENTRY_W-1:0]   ram_rdata;
  rhct_pkg::entry_t               rd_entry;
  rhct_pkg::entry_t               hit_entry;
  logic                           in_xfer;
  logic [rhct_pkg::CMP_W-1:0]     pos_ext;
  logic [rhct_pkg::CMP_W-1:0]     cnt_ext;
  logic [rhct_pkg::CMP_W-1:0]     idx_next_ext;

  // True when entry a belongs behind entry b
  function automatic logic is_lesser(input rhct_pkg::entry_t a, input rhct_pkg::entry_t b);
    logic res;
    if (a.count != b.count) begin
      res = (a.count < b.count);
    end else begin
      res = (a.rank < b.rank);
    end
    return res;
  endfunction

  // Table index as the 8-bit position field
  function automatic logic [7:0] pos8(input logic [rhct_pkg::ADDR_W-1:0] a);
    logic [rhct_pkg::CMP_W-1:0] w;
    w = rhct_pkg::CMP_W'(a);
    return w[7:0];
  endfunction

  function automatic rhct_pkg::rsp_t make_rsp(input rhct_pkg::entry_t e,
                                              input logic [rhct_pkg::ADDR_W-1:0] a);
    rhct_pkg::rsp_t r;
    r.found        = 1'b1;
    r.entry_key    = e.key;
    r.entry_count  = e.count;
    r.entry_rank   = e.rank;
    r.new_position = pos8(a);
    return r;
  endfunction

  rhct_ram #(
    .WIDTH (rhct_pkg::ENTRY_W),
    .DEPTH (rhct_pkg::TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry     = rhct_pkg::entry_t'(ram_rdata);
  assign in_ready_o   = (state_q == S_IDLE);
  assign in_xfer      = in_valid_i && in_ready_o;
  assign pos_ext      = rhct_pkg::CMP_W'(in_req_i.position);
  assign cnt_ext      = rhct_pkg::CMP_W'(cnt_q);
  assign idx_next_ext = rhct_pkg::CMP_W'(idx_q) + rhct_pkg::CMP_W'(1);

  // Bump the count of the entry just read, saturating
  always_comb begin
    hit_entry = rd_entry;
    if (rd_entry.count != rhct_pkg::COUNT_MAX) begin
      hit_entry.count = rd_entry.count + 8'd1;
    end
  end

  // Sequence requests over the entry RAM
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    key_d       = key_q;
    mv_d        = mv_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = mv_q;
    ram_raddr   = idx_q;

    // Drop the result once the consumer takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_d   = '0;
          state_d = S_EMIT;
          unique case (in_req_i.req_type)
            rhct_pkg::REQ_LOAD: begin
              if (cnt_q < rhct_pkg::CNT_W'(rhct_pkg::TABLE_DEPTH)) begin
                ram_we          = 1'b1;
                ram_waddr       = rhct_pkg::ADDR_W'(cnt_q);
                ram_wdata.key   = in_req_i.url_key;
                ram_wdata.count = '0;
                ram_wdata.rank  = in_req_i.page_rank;
                res_d           = make_rsp(ram_wdata, rhct_pkg::ADDR_W'(cnt_q));
                cnt_d           = cnt_q + rhct_pkg::CNT_W'(1);
              end
            end
            rhct_pkg::REQ_SIGHT: begin
              if (cnt_q != '0) begin
                key_d     = in_req_i.url_key;
                idx_d     = '0;
                ram_raddr = '0;
                state_d   = S_SEARCH;
              end
            end
            rhct_pkg::REQ_READ: begin
              if (pos_ext < cnt_ext) begin
                idx_d     = pos_ext[rhct_pkg::ADDR_W-1:0];
                ram_raddr = pos_ext[rhct_pkg::ADDR_W-1:0];
                state_d   = S_RDWAIT;
              end
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end

      // Scan one entry per cycle, prefetching the next
      S_SEARCH: begin
        if (rd_entry.key == key_q) begin
          if (idx_q == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = hit_entry;
            res_d     = make_rsp(hit_entry, '0);
            state_d   = S_EMIT;
          end else begin
            mv_d      = hit_entry;
            ram_raddr = idx_q - rhct_pkg::ADDR_W'(1);
            state_d   = S_BUBBLE;
          end
        end else if (idx_next_ext >= cnt_ext) begin
          res_d   = '0;
          state_d = S_EMIT;
        end else begin
          idx_d     = idx_q + rhct_pkg::ADDR_W'(1);
          ram_raddr = idx_q + rhct_pkg::ADDR_W'(1);
        end
      end

      // Compare with the neighbor ahead; shift it back or settle
      S_BUBBLE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        if (is_lesser(rd_entry, mv_q)) begin
          ram_wdata = rd_entry;
          idx_d     = idx_q - rhct_pkg::ADDR_W'(1);
          if (idx_q == rhct_pkg::ADDR_W'(1)) begin
            state_d = S_FINAL;
          end else begin
            ram_raddr = idx_q - rhct_pkg::ADDR_W'(2);
          end
        end else begin
          ram_wdata = mv_q;
          res_d     = make_rsp(mv_q, idx_q);
          state_d   = S_EMIT;
        end
      end

      // Place the moving entry at the front
      S_FINAL: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = mv_q;
        res_d     = make_rsp(mv_q, '0);
        state_d   = S_EMIT;
      end

      S_RDWAIT: begin
        res_d   = make_rsp(rd_entry, idx_q);
        state_d = S_EMIT;
      end

      // Hand the result to the output register when it is free
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      key_q       <= '0;
      mv_q        <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      key_q       <= key_d;
      mv_q        <= mv_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_rsp_q   <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: sv/rhct_checker.sv
// Port-level checks for the ranked hit-count table, bound to the top level.
module rhct_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input rhct_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rhct_pkg::rsp_t out_rsp_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // A miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.found |->
      out_rsp_o.entry_key == '0 && out_rsp_o.entry_count == '0 &&
      out_rsp_o.entry_rank == '0 && out_rsp_o.new_position == '0)
    else $error("miss result with nonzero fields");

  // Only one request in flight: busy right after a transfer
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // A new result appears only out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o && !out_ready_i) && $past(rst_ni) |->
      $past(!in_ready_o) || $past(out_valid_o))
    else $error("result without request in progress");

endmodule

bind ranked_hit_count_table rhct_checker u_rhct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
